>>> sv/gaussian_band_force_core_defines.svh
// Assertion macros for the Gaussian band force core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef GAUSSIAN_BAND_FORCE_CORE_DEFINES_SVH
`define GAUSSIAN_BAND_FORCE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define GBF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbf same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define GBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbf next-cycle check failed");

`endif

>>> sv/gbf_pkg.sv
// Shared constants, types and the exp ROM generator for the Gaussian band force core.
// Depends on nothing; used by the channel interfaces and every module.
`default_nettype none

package gbf_pkg;

    localparam int VEC_BITS       = 20;  // axis / direction components, Q2.18
    localparam int Y_BITS         = 19;  // in-band projection, 10 fraction bits
    localparam int SQ_BITS        = 38;  // y^2
    localparam int ARG_BITS       = 54;  // y^2 * inverse_width
    localparam int ARG_SHIFT      = 31;  // 32 table steps per unit
    localparam int IDX_FULL_BITS  = ARG_BITS - ARG_SHIFT;
    localparam int E_BITS         = 17;  // exp value, Q16 (1.0 fits)
    localparam int AMP_BITS       = 16;
    localparam int IW_BITS        = 16;
    localparam int BL_BITS        = 19;
    localparam int MAG_BITS       = AMP_BITS + E_BITS;
    localparam int PROD_BITS      = MAG_BITS + VEC_BITS;
    localparam int RND_SHIFT      = 34;
    localparam int OUT_BITS       = 24;
    localparam int CFG_DATA_BITS  = 60;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;

    // register map
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_POINT     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_UNIT       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_LENGTH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERSE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FORCE_DIRECTION = 3'd5;

    // advance strobes for the three stages of one pipeline section
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
    } gbf_adv_t;

    // exp(-idx/32) in Q16: square-and-multiply in Q30, round half up each step
    function automatic logic [E_BITS-1:0] exp_rom_q16(input int unsigned idx);
        logic [63:0] p;
        logic [63:0] b;
        logic [31:0] n;
        p = 64'd1 << 30;
        b = EXP_STEP_Q30;
        n = idx;
        for (int i = 0; i < 16; i++)
        begin
            if (n[0])
            begin
                p = (p * b + (64'd1 << 29)) >> 30;
            end
            b = (b * b + (64'd1 << 29)) >> 30;
            n = n >> 1;
        end
        p = (p + (64'd1 << 13)) >> 14;
        return p[E_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/gbf_if.sv
// Valid/ready channel interfaces: particle position, force result, register write.
// Depends on gbf_pkg for payload widths.
`default_nettype none

interface gbf_pos_if
    import gbf_pkg::*;
#(
    parameter int COORD_BITS = 20
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface gbf_force_if
    import gbf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] force_x;
    logic signed [OUT_BITS-1:0] force_y;
    logic signed [OUT_BITS-1:0] force_z;
    logic                       in_band;

    modport source (output valid, force_x, force_y, force_z, in_band, input ready);
    modport sink   (input valid, force_x, force_y, force_z, in_band, output ready);
endinterface

interface gbf_cfg_if
    import gbf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/gaussian_band_force_core.sv
// Gaussian band force core: projection, Gaussian lookup and scaling in one pipeline.
// Throughput one position per cycle while the result is taken; each of the 9 stages has
// its own valid bit and stalls only when it holds data the next stage cannot take, so
// bubbles collapse. rst_n (async, low) clears the stage valid bits and all six config
// registers to 0; datapath registers are not reset. The config port is always ready.
`default_nettype none
`include "gaussian_band_force_core_defines.svh"

module gaussian_band_force_core
    import gbf_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter int COORD_BITS      = 20
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gbf_pos_if.sink    position,
    gbf_force_if.source result,
    gbf_cfg_if.sink    cfg
);

    localparam int NS = 9;  // pipeline depth: 3 sections of 3 stages

    // configuration registers
    logic [CFG_DATA_BITS-1:0] start_point_reg;
    logic [CFG_DATA_BITS-1:0] axis_unit_reg;
    logic [BL_BITS-1:0]       band_length_reg;
    logic [IW_BITS-1:0]       inverse_width_reg;
    logic [AMP_BITS-1:0]      amplitude_reg;
    logic [CFG_DATA_BITS-1:0] force_direction_reg;

    // pipeline control
    logic [NS-1:0] stage_v_reg;
    logic [NS-1:0] stage_v_next;
    logic [NS-1:0] adv;

    // per-section advance strobes (s0 is the MSB of the packed struct)
    gbf_adv_t adv_project;
    gbf_adv_t adv_gauss;
    gbf_adv_t adv_scale;

    // section hand-off
    logic [Y_BITS-1:0] y10;
    logic              inb_a;
    logic [E_BITS-1:0] e16;
    logic              inb_b;

    // all three force components are zero
    logic result_zero;

    //------------------------------------------------------------------
    // Register writes: one transfer per cycle, unused bits dropped,
    // unknown indexes ignored.
    //------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_point_reg     <= '0;
            axis_unit_reg       <= '0;
            band_length_reg     <= '0;
            inverse_width_reg   <= '0;
            amplitude_reg       <= '0;
            force_direction_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_POINT:     start_point_reg     <= cfg.data;
                CFG_AXIS_UNIT:       axis_unit_reg       <= cfg.data;
                CFG_BAND_LENGTH:     band_length_reg     <= cfg.data[BL_BITS-1:0];
                CFG_INVERSE_WIDTH:   inverse_width_reg   <= cfg.data[IW_BITS-1:0];
                CFG_AMPLITUDE:       amplitude_reg       <= cfg.data[AMP_BITS-1:0];
                CFG_FORCE_DIRECTION: force_direction_reg <= cfg.data;
                default:             ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Stall control. A stage advances when it is empty or the stage after
    // it advances; the last stage advances when empty or taken downstream.
    //------------------------------------------------------------------
    always_comb
    begin
        adv[NS-1] = !stage_v_reg[NS-1] || result.ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !stage_v_reg[s] || adv[s+1];
        end
    end

    always_comb
    begin
        stage_v_next[0] = adv[0] ? position.valid : stage_v_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            stage_v_next[s] = adv[s] ? stage_v_reg[s-1] : stage_v_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
        end
    end

    assign position.ready = adv[0];

    assign adv_project = {adv[0], adv[1], adv[2]};
    assign adv_gauss   = {adv[3], adv[4], adv[5]};
    assign adv_scale   = {adv[6], adv[7], adv[8]};

    //------------------------------------------------------------------
    // Datapath sections
    //------------------------------------------------------------------
    // stages 1-3: offset, axis products, sum + band test
    gbf_project #(
        .COORD_BITS (COORD_BITS)
    ) u_project (
        .clk         (clk),
        .adv         (adv_project),
        .pos_x       (position.pos_x),
        .pos_y       (position.pos_y),
        .pos_z       (position.pos_z),
        .start_point (start_point_reg),
        .axis_unit   (axis_unit_reg),
        .band_length (band_length_reg),
        .y10         (y10),
        .in_band     (inb_a)
    );

    // stages 4-6: y^2, argument and table index, ROM read
    gbf_gauss #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_gauss (
        .clk           (clk),
        .adv           (adv_gauss),
        .y10           (y10),
        .in_band       (inb_a),
        .inverse_width (inverse_width_reg),
        .e16           (e16),
        .in_band_out   (inb_b)
    );

    // stages 7-9: magnitude, direction products, rounding; stage 9 drives the port
    gbf_scale u_scale (
        .clk             (clk),
        .adv             (adv_scale),
        .e16             (e16),
        .in_band         (inb_b),
        .amplitude       (amplitude_reg),
        .force_direction (force_direction_reg),
        .force_x         (result.force_x),
        .force_y         (result.force_y),
        .force_z         (result.force_z),
        .in_band_out     (result.in_band)
    );

    assign result.valid = stage_v_reg[NS-1];

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    assign result_zero = (result.force_x == '0) && (result.force_y == '0)
                         && (result.force_z == '0);

    // out-of-band results carry zero force (ROM gate follows the band flag)
    `GBF_ASSERT_IMPL(a_out_band_zero, result.valid && !result.in_band, result_zero)
    // an accepted position always lands in the first stage
    `GBF_ASSERT_NEXT(a_accept_lands, position.valid && position.ready, stage_v_reg[0])
    // a full pipeline with a stalled output takes no new position
    `GBF_ASSERT_IMPL(a_full_blocks, (&stage_v_reg) && !result.ready, !position.ready)

endmodule

`default_nettype wire

>>> sv/gbf_project.sv
// Projection section: offset from start point, dot product with the axis, band test.
// Depends on gbf_pkg; three register stages advanced by the top-level control.
`default_nettype none

module gbf_project
    import gbf_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  wire logic                         clk,
    input  wire gbf_adv_t                     adv,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [COORD_BITS-1:0] pos_z,
    input  wire logic [CFG_DATA_BITS-1:0]     start_point,
    input  wire logic [CFG_DATA_BITS-1:0]     axis_unit,
    input  wire logic [BL_BITS-1:0]           band_length,
    output logic [Y_BITS-1:0]                 y10,
    output logic                              in_band
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = DW + VEC_BITS;
    localparam int SW = PW + 2;
    localparam int LIM_BITS = BL_BITS + 18 + 1;
    localparam int CW = (SW > LIM_BITS) ? SW : LIM_BITS;

    logic [63:0]                  sp_pad;
    logic signed [COORD_BITS-1:0] pos [3];
    logic signed [COORD_BITS-1:0] sp  [3];
    logic signed [VEC_BITS-1:0]   ax  [3];
    logic signed [DW-1:0]         d_reg [3];
    logic signed [PW-1:0]         p_reg [3];
    logic signed [CW-1:0]         y_ext;
    logic signed [CW-1:0]         lim;
    logic [Y_BITS-1:0]            y10_reg;
    logic                         in_band_reg;

    assign sp_pad = {{(64 - CFG_DATA_BITS){1'b0}}, start_point};
    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        assign sp[k] = $signed(sp_pad[k*COORD_BITS +: COORD_BITS]);
        assign ax[k] = $signed(axis_unit[k*VEC_BITS +: VEC_BITS]);

        always_ff @(posedge clk)
        begin
            if (adv.s0)
            begin
                d_reg[k] <= DW'(pos[k]) - DW'(sp[k]);
            end
            if (adv.s1)
            begin
                p_reg[k] <= PW'(d_reg[k]) * PW'(ax[k]);
            end
        end
    end

    // projection has 28 fraction bits; band test at full precision
    assign y_ext = CW'(SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2]));
    assign lim   = CW'($signed({1'b0, band_length, 18'd0}));

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            y10_reg     <= y_ext[18 +: Y_BITS];
            in_band_reg <= !y_ext[CW-1] && (y_ext <= lim);
        end
    end

    assign y10     = y10_reg;
    assign in_band = in_band_reg;

endmodule

`default_nettype wire

>>> sv/gbf_gauss.sv
// Gaussian section: y^2, scaled argument, exp ROM lookup with registered read.
// Depends on gbf_pkg (ROM contents); three register stages.
`default_nettype none

module gbf_gauss
    import gbf_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic                 clk,
    input  wire gbf_adv_t             adv,
    input  wire logic [Y_BITS-1:0]    y10,
    input  wire logic                 in_band,
    input  wire logic [IW_BITS-1:0]   inverse_width,
    output logic [E_BITS-1:0]         e16,
    output logic                      in_band_out
);

    localparam int IW = $clog2(EXP_TABLE_DEPTH);

    logic [E_BITS-1:0]        rom [EXP_TABLE_DEPTH];
    logic [SQ_BITS-1:0]       sq_reg;
    logic                     inb4_reg;
    logic [ARG_BITS-1:0]      arg;
    logic [IDX_FULL_BITS-1:0] idx_full;
    logic [IW-1:0]            idx_reg;
    logic                     hit_reg;
    logic                     inb5_reg;
    logic [E_BITS-1:0]        e16_reg;
    logic                     inb6_reg;

    for (genvar i = 0; i < EXP_TABLE_DEPTH; i++)
    begin : g_rom
        assign rom[i] = exp_rom_q16(i);
    end

    assign arg      = ARG_BITS'(sq_reg) * ARG_BITS'(inverse_width);
    assign idx_full = arg[ARG_SHIFT +: IDX_FULL_BITS];

    always_ff @(posedge clk)
    begin
        if (adv.s0)
        begin
            sq_reg   <= SQ_BITS'(y10) * SQ_BITS'(y10);
            inb4_reg <= in_band;
        end
        if (adv.s1)
        begin
            // out of band or past the table end both read as zero
            hit_reg  <= inb4_reg && (idx_full < IDX_FULL_BITS'(EXP_TABLE_DEPTH));
            idx_reg  <= idx_full[IW-1:0];
            inb5_reg <= inb4_reg;
        end
        if (adv.s2)
        begin
            e16_reg  <= hit_reg ? rom[idx_reg] : '0;
            inb6_reg <= inb5_reg;
        end
    end

    assign e16         = e16_reg;
    assign in_band_out = inb6_reg;

endmodule

`default_nettype wire

>>> sv/gbf_scale.sv
// Scaling section: amplitude*exp, times each direction component, round to Q8.
// Depends on gbf_pkg; the last stage is the block's output register.
`default_nettype none

module gbf_scale
    import gbf_pkg::*;
(
    input  wire logic                   clk,
    input  wire gbf_adv_t               adv,
    input  wire logic [E_BITS-1:0]      e16,
    input  wire logic                   in_band,
    input  wire logic [AMP_BITS-1:0]    amplitude,
    input  wire logic [CFG_DATA_BITS-1:0] force_direction,
    output logic signed [OUT_BITS-1:0]  force_x,
    output logic signed [OUT_BITS-1:0]  force_y,
    output logic signed [OUT_BITS-1:0]  force_z,
    output logic                        in_band_out
);

    localparam int Q_BITS = PROD_BITS - RND_SHIFT;

    logic [MAG_BITS-1:0]        mag_reg;
    logic                       inb7_reg;
    logic [PROD_BITS-1:0]       prod_reg [3];
    logic                       neg_reg  [3];
    logic                       inb8_reg;
    logic signed [OUT_BITS-1:0] f_reg    [3];
    logic                       inb9_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s0)
        begin
            mag_reg  <= MAG_BITS'(amplitude) * MAG_BITS'(e16);
            inb7_reg <= in_band;
        end
        if (adv.s1)
        begin
            inb8_reg <= inb7_reg;
        end
        if (adv.s2)
        begin
            inb9_reg <= inb8_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [VEC_BITS-1:0]  dir;
        logic [VEC_BITS-1:0]  ad;
        logic [PROD_BITS-1:0] rnd;
        logic [Q_BITS-1:0]    q;

        assign dir = force_direction[k*VEC_BITS +: VEC_BITS];
        assign ad  = dir[VEC_BITS-1] ? (VEC_BITS'(0) - dir) : dir;
        assign rnd = prod_reg[k] + (PROD_BITS'(1) << (RND_SHIFT - 1));
        assign q   = rnd[RND_SHIFT +: Q_BITS];

        // |q| stays below 2^18, so it fits the 24-bit output without any clamp
        always_ff @(posedge clk)
        begin
            if (adv.s1)
            begin
                prod_reg[k] <= PROD_BITS'(mag_reg) * PROD_BITS'(ad);
                neg_reg[k]  <= dir[VEC_BITS-1];
            end
            if (adv.s2)
            begin
                f_reg[k] <= neg_reg[k] ? (OUT_BITS'(0) - OUT_BITS'(q)) : OUT_BITS'(q);
            end
        end
    end

    assign force_x     = f_reg[0];
    assign force_y     = f_reg[1];
    assign force_z     = f_reg[2];
    assign in_band_out = inb9_reg;

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for gaussian_band_force_core: random band setups, positions and handshake gaps.
// Depends on gbf_pkg, the gbf_*_if channel interfaces and the core itself.
`timescale 1ns / 100ps

module tb
    import gbf_pkg::*;
();

    localparam int COORD_BITS  = 20;
    localparam int EXP_DEPTH   = 256;
    localparam int PIPE_DEPTH  = 9;       // stages in the core's pipeline
    localparam int Q18_ONE     = 262144;  // 1.0 for axis / direction components
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 74;
    localparam int HOLD_CYCLES = 160;     // long result-side hold-off

    localparam longint OUT_HI = 8388607;
    localparam longint OUT_LO = -8388608;

    // indexes past the register map; writes there must leave every register alone
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } pos_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] fx;
        logic signed [OUT_BITS-1:0] fy;
        logic signed [OUT_BITS-1:0] fz;
        logic                       in_band;
    } force_t;

    logic clk;
    logic rst_n;

    gbf_pos_if #(.COORD_BITS(COORD_BITS)) pos_ch ();
    gbf_force_if                          res_ch ();
    gbf_cfg_if                            cfg_ch ();

    gaussian_band_force_core #(
        .EXP_TABLE_DEPTH(EXP_DEPTH),
        .COORD_BITS     (COORD_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .position(pos_ch),
        .result  (res_ch),
        .cfg     (cfg_ch)
    );

    // mirror of the core's register file, updated on every config transfer
    logic [CFG_DATA_BITS-1:0] start_reg = '0;
    logic [CFG_DATA_BITS-1:0] axis_reg  = '0;
    logic [BL_BITS-1:0]       len_reg   = '0;
    logic [IW_BITS-1:0]       iw_reg    = '0;
    logic [AMP_BITS-1:0]      amp_reg   = '0;
    logic [CFG_DATA_BITS-1:0] dir_reg   = '0;

    longint unsigned exp_q16_rom [EXP_DEPTH];

    pos_t   pos_backlog [$];   // positions waiting for the driver
    force_t force_due   [$];   // predicted forces, oldest first

    int src_gap_max   = 0;
    int snk_stall_max = 0;
    bit sink_hold     = 1'b0;
    int src_wait;
    int snk_wait;

    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int band_hits       = 0;
    int cfg_writes      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // signed 20-bit component k of a packed x,y,z register
    function automatic longint comp_of(input logic [CFG_DATA_BITS-1:0] r, input int k);
        logic signed [VEC_BITS-1:0] c;
        c = r[k*VEC_BITS +: VEC_BITS];
        return c;
    endfunction

    // exp(-n/32) in Q16: repeated squaring of the Q30 step, half-up rounding
    function automatic longint unsigned decay_q16(input int n);
        longint unsigned acc;
        longint unsigned step;
        int              rest;
        acc  = 64'd1 << 30;
        step = EXP_STEP_Q30;
        rest = n;
        while (rest != 0)
        begin
            if (rest & 1)
                acc = (acc * step + (64'd1 << 29)) >> 30;
            step = (step * step + (64'd1 << 29)) >> 30;
            rest = rest >> 1;
        end
        return (acc + (64'd1 << 13)) >> 14;
    endfunction

    // force on one particle under the current register settings
    function automatic force_t band_force_of(input pos_t p);
        force_t                     r;
        longint                     y28;
        longint                     dir;
        longint                     f;
        longint unsigned            y10;
        longint unsigned            arg;
        longint unsigned            idx;
        longint unsigned            e16;
        longint unsigned            mag;
        longint unsigned            ad;
        longint unsigned            q;
        logic signed [COORD_BITS-1:0] pc [3];
        logic signed [OUT_BITS-1:0]   fv [3];
        pc[0] = p.x;
        pc[1] = p.y;
        pc[2] = p.z;
        fv[0] = '0;
        fv[1] = '0;
        fv[2] = '0;
        // projection onto the axis, exact with 28 fraction bits
        y28 = 0;
        for (int k = 0; k < 3; k++)
            y28 += (longint'(pc[k]) - comp_of(start_reg, k)) * comp_of(axis_reg, k);
        r = '0;
        r.in_band = (y28 >= 0) && (y28 <= (longint'(len_reg) << 18));
        if (r.in_band)
        begin
            y10 = y28 >> 18;
            arg = y10 * y10 * iw_reg;
            idx = arg >> ARG_SHIFT;
            e16 = (idx < EXP_DEPTH) ? exp_q16_rom[idx] : 64'd0;  // zero past the table
            mag = amp_reg * e16;
            for (int k = 0; k < 3; k++)
            begin
                dir = comp_of(dir_reg, k);
                ad  = (dir < 0) ? -dir : dir;
                q   = (mag * ad + (64'd1 << 33)) >> 34;   // half away from zero
                f   = (q > 64'd8388608) ? 8388608 : longint'(q);
                if (dir < 0)
                    f = -f;
                if (f > OUT_HI)
                    f = OUT_HI;
                if (f < OUT_LO)
                    f = OUT_LO;
                fv[k] = f[OUT_BITS-1:0];
            end
        end
        r.fx = fv[0];
        r.fy = fv[1];
        r.fz = fv[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Position driver: pops the backlog, holds each item until its transfer,
    // then idles for the gap drawn when the item was loaded.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : pos_driver
        pos_t nxt;
        if (!rst_n)
        begin
            pos_ch.valid <= 1'b0;
            pos_ch.pos_x <= '0;
            pos_ch.pos_y <= '0;
            pos_ch.pos_z <= '0;
            src_wait     <= 0;
        end
        else
        begin
            if (pos_ch.valid && pos_ch.ready)
            begin
                // prediction happens at the transfer, registers are stable then
                nxt.x = pos_ch.pos_x;
                nxt.y = pos_ch.pos_y;
                nxt.z = pos_ch.pos_z;
                force_due.push_back(band_force_of(nxt));
                items_sent++;
            end
            if (pos_ch.valid && !pos_ch.ready)
            begin
                // stalled: keep offering the same item
            end
            else if (src_wait > 0)
            begin
                pos_ch.valid <= 1'b0;
                src_wait     <= src_wait - 1;
            end
            else if (pos_backlog.size() != 0)
            begin
                nxt = pos_backlog.pop_front();
                pos_ch.pos_x <= nxt.x;
                pos_ch.pos_y <= nxt.y;
                pos_ch.pos_z <= nxt.z;
                pos_ch.valid <= 1'b1;
                src_wait     <= $urandom_range(0, src_gap_max);
            end
            else
            begin
                pos_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic signed [OUT_BITS-1:0] want,
                               input logic signed [OUT_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Force monitor: compares each result transfer with the oldest prediction
    // and throttles ready with per-item stalls or the long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : force_monitor
        force_t      want;
        int unsigned stall;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            snk_wait     <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (force_due.size() == 0)
                begin
                    $display("%0t unexpected result: x %0d y %0d z %0d in_band %0b", $time,
                             res_ch.force_x, res_ch.force_y, res_ch.force_z, res_ch.in_band);
                    mismatches++;
                end
                else
                begin
                    want = force_due.pop_front();
                    check_field("force_x", want.fx, res_ch.force_x);
                    check_field("force_y", want.fy, res_ch.force_y);
                    check_field("force_z", want.fz, res_ch.force_z);
                    check_field("in_band", want.in_band, res_ch.in_band);
                    results_checked++;
                    if (want.in_band)
                        band_hits++;
                end
            end
            if (sink_hold)
            begin
                res_ch.ready <= 1'b0;
            end
            else if (res_ch.valid && res_ch.ready)
            begin
                stall = $urandom_range(0, snk_stall_max);
                res_ch.ready <= (stall == 0);
                snk_wait     <= (stall == 0) ? 0 : stall - 1;
            end
            else if (snk_wait > 0)
            begin
                res_ch.ready <= 1'b0;
                snk_wait     <= snk_wait - 1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand60();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DATA_BITS-1:0];
    endfunction

    // unit vector in Q18, either along one coordinate or in a random direction
    function automatic logic [CFG_DATA_BITS-1:0] rand_unit_q18(input bit aligned);
        real                      c [3];
        real                      nrm;
        int                       k;
        logic [CFG_DATA_BITS-1:0] v;
        v   = '0;
        nrm = 0.0;
        if (aligned)
        begin
            k = $urandom_range(0, 2);
            v[k*VEC_BITS +: VEC_BITS] = $urandom_range(0, 1) ? 20'sd262144 : -20'sd262144;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                c[i] = rand_span(-1000, 1000) / 1000.0;
                nrm += c[i] * c[i];
            end
            if (nrm < 0.01)
            begin
                c[0] = 1.0;
                nrm  = 1.0;
            end
            nrm = $sqrt(nrm);
            for (int i = 0; i < 3; i++)
                v[i*VEC_BITS +: VEC_BITS] = 20'($rtoi(c[i] / nrm * Q18_ONE));
        end
        return v;
    endfunction

    // one config transfer; the mirror takes the value masked to the register width
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_START_POINT:     start_reg = val;
            CFG_AXIS_UNIT:       axis_reg  = val;
            CFG_BAND_LENGTH:     len_reg   = val[BL_BITS-1:0];
            CFG_INVERSE_WIDTH:   iw_reg    = val[IW_BITS-1:0];
            CFG_AMPLITUDE:       amp_reg   = val[AMP_BITS-1:0];
            CFG_FORCE_DIRECTION: dir_reg   = val;
            default:             ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic push_pos(input int x, input int y, input int z);
        pos_t p;
        p.x = x[COORD_BITS-1:0];
        p.y = y[COORD_BITS-1:0];
        p.z = z[COORD_BITS-1:0];
        pos_backlog.push_back(p);
    endtask

    task automatic push_noise_item();
        push_pos(rand_span(-524288, 524287), rand_span(-524288, 524287),
                 rand_span(-524288, 524287));
    endtask

    // a well-formed band setup: at the far edge the exp index is aimed at 150 to 400,
    // so it can run past the table end, unless the width is clamped or drawn at random;
    // garbage above each narrow register checks the masking
    task automatic set_band(input bit aligned, input bit wild_iw);
        logic [CFG_DATA_BITS-1:0] sp;
        logic [CFG_DATA_BITS-1:0] garbage;
        logic [BL_BITS-1:0]       len;
        longint                   iw;
        sp = '0;
        for (int k = 0; k < 3; k++)
            sp[k*COORD_BITS +: COORD_BITS] = 20'(rand_span(-200000, 200000));
        write_reg(CFG_START_POINT, sp);
        write_reg(CFG_AXIS_UNIT, rand_unit_q18(aligned));
        garbage = rand60();
        len     = 19'(rand_span(1024, 300000));
        write_reg(CFG_BAND_LENGTH, {garbage[CFG_DATA_BITS-1:BL_BITS], len});
        iw = (longint'(rand_span(150, 400)) << ARG_SHIFT) / (longint'(len) * len);
        if (iw > 65535)
            iw = 65535;
        if (wild_iw)
            iw = $urandom_range(0, 65535);
        garbage = rand60();
        write_reg(CFG_INVERSE_WIDTH, {garbage[CFG_DATA_BITS-1:IW_BITS], iw[IW_BITS-1:0]});
        garbage = rand60();
        write_reg(CFG_AMPLITUDE, {garbage[CFG_DATA_BITS-1:AMP_BITS], 16'($urandom)});
        write_reg(CFG_FORCE_DIRECTION,
                  ($urandom_range(0, 3) == 0) ? rand60() : rand_unit_q18(1'b0));
    endtask

    // position near the axis between a bit before the start and a bit past
    // the end, sometimes exactly on a band edge
    task automatic push_band_item();
        real    t;
        longint c [3];
        if ($urandom_range(0, 9) == 0)
            t = $urandom_range(0, 1) ? real'(len_reg) : 0.0;
        else
            t = real'(len_reg) * (rand_span(-100, 1100) / 1000.0);
        for (int k = 0; k < 3; k++)
        begin
            c[k] = comp_of(start_reg, k) + $rtoi(t * comp_of(axis_reg, k) / Q18_ONE);
            if ($urandom_range(0, 1))
                c[k] += rand_span(-2000, 2000);
            if (c[k] > 524287)
                c[k] = 524287;
            if (c[k] < -524288)
                c[k] = -524288;
        end
        push_pos(int'(c[0]), int'(c[1]), int'(c[2]));
    endtask

    // sender pauses until every predicted force has come back, then lets the
    // pipeline latency pass so the core is idle for config writes
    task automatic wait_idle();
        @(negedge clk);
        while (pos_backlog.size() != 0 || pos_ch.valid || force_due.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 3) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        clk          = 1'b0;
        rst_n        = 1'b0;
        for (int i = 0; i < EXP_DEPTH; i++)
            exp_q16_rom[i] = decay_q16(i);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: reset settings, zero length band, every projection is 0
        src_gap_max   = 4;
        snk_stall_max = 4;
        push_pos(0, 0, 0);
        push_pos(-524288, -524288, -524288);
        push_pos(524287, 524287, 524287);
        push_pos(-524288, 524287, 0);
        wait_idle();

        // --- directed: x axis, exp flat (zero width term), band edges, direction
        // extremes; writes past the register map must change nothing
        write_reg(CFG_SPARE_LO, rand60());
        write_reg(CFG_SPARE_HI, '1);
        write_reg(CFG_AXIS_UNIT, 60'(Q18_ONE));
        write_reg(CFG_BAND_LENGTH, {41'h1FFFFFFFFFF, 19'd102400});
        write_reg(CFG_AMPLITUDE, '1);
        write_reg(CFG_FORCE_DIRECTION, {20'sd262144, 20'sd524287, 20'h80000});
        push_pos(0, rand_span(-524288, 524287), rand_span(-524288, 524287));
        push_pos(51200, rand_span(-524288, 524287), rand_span(-524288, 524287));
        push_pos(102400, rand_span(-524288, 524287), rand_span(-524288, 524287));
        push_pos(102401, 0, 0);
        push_pos(-1, 0, 0);
        push_pos(524287, 0, 0);
        wait_idle();

        // --- directed: steepest width term, walk the index up to and past the table end
        write_reg(CFG_START_POINT, {20'd0, -20'sd1000, 20'sd3000});
        write_reg(CFG_INVERSE_WIDTH, 16'hFFFF);
        push_pos(3000, 0, 0);
        push_pos(4024, 0, 0);
        push_pos(5896, 0, 0);
        push_pos(5900, 0, 0);
        push_pos(8000, 0, 0);
        push_pos(103000, 0, 0);
        wait_idle();

        // --- random phases, each with its own settings and idle pattern
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin src_gap_max = 0;  snk_stall_max = 0;  end
                1:       begin src_gap_max = 16; snk_stall_max = 16; end
                2:       begin src_gap_max = 16; snk_stall_max = 0;  end
                default: begin src_gap_max = 0;  snk_stall_max = 16; end
            endcase
            if (ph == 6)
            begin
                // everything random, including axes of any length
                write_reg(CFG_START_POINT, rand60());
                write_reg(CFG_AXIS_UNIT, rand60());
                write_reg(CFG_BAND_LENGTH, rand60());
                write_reg(CFG_INVERSE_WIDTH, rand60());
                write_reg(CFG_AMPLITUDE, rand60());
                write_reg(CFG_FORCE_DIRECTION, rand60());
                for (int i = 0; i < PHASE_ITEMS; i++)
                    push_noise_item();
            end
            else if (ph == 7)
            begin
                // all-ones registers, then start at the minimum corner with the
                // largest axis, direction and amplitude
                write_reg(CFG_START_POINT, '1);
                write_reg(CFG_AXIS_UNIT, '1);
                write_reg(CFG_BAND_LENGTH, '1);
                write_reg(CFG_INVERSE_WIDTH, '1);
                write_reg(CFG_AMPLITUDE, '1);
                write_reg(CFG_FORCE_DIRECTION, '1);
                for (int i = 0; i < PHASE_ITEMS / 2; i++)
                    push_noise_item();
                wait_idle();
                write_reg(CFG_START_POINT, {3{20'h80000}});
                write_reg(CFG_AXIS_UNIT, {3{20'h7FFFF}});
                write_reg(CFG_INVERSE_WIDTH, '0);
                write_reg(CFG_FORCE_DIRECTION, {3{20'h80000}});
                for (int i = 0; i < PHASE_ITEMS / 2; i++)
                    push_pos(rand_span(-524288, -400000), rand_span(-524288, -400000),
                             rand_span(-524288, -400000));
            end
            else
            begin
                set_band(ph % 3 == 0, ph == 4 || ph == 9);
                if (ph == 8)
                begin
                    src_gap_max   = 0;
                    snk_stall_max = 0;
                end
                for (int i = 0; i < PHASE_ITEMS; i++)
                begin
                    if ($urandom_range(0, 6) != 0)
                        push_band_item();
                    else
                        push_noise_item();
                end
                if (ph == 8)
                begin
                    // result side holds off while positions keep coming, so the
                    // pipeline fills and back-pressures the input
                    sink_hold = 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    sink_hold = 1'b0;
                end
            end
            wait_idle();
        end

        repeat (20) @(negedge clk);
        if (force_due.size() != 0)
        begin
            $display("%0t %0d predicted results never arrived", $time, force_due.size());
            mismatches++;
        end
        $display("Covered %0d positions over %0d register writes; %0d results checked",
                 items_sent, cfg_writes, results_checked);
        $display("%0d results inside the band, %0d outside", band_hits,
                 results_checked - band_hits);
        if (mismatches == 0)
            $display("[gaussian_band_force_core] OK");
        else
            $display("[gaussian_band_force_core] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("%0t timeout with %0d results still due", $time, force_due.size());
        $display("[gaussian_band_force_core] ERROR");
        $finish;
    end

endmodule

>>> gaussian_band_force_core.f
+incdir+sv
sv/gbf_pkg.sv
sv/gbf_if.sv
sv/gbf_project.sv
sv/gbf_gauss.sv
sv/gbf_scale.sv
sv/gaussian_band_force_core.sv
verif/tb.sv
